// ===== hdl/phase_average_pi_regulator_defines.svh =====
// ----------------------------------------------------------------------------
// phase_average_pi_regulator_defines
// assertion macros shared by the checker of the phase regulator
// ----------------------------------------------------------------------------
`ifndef PHASE_AVERAGE_PI_REGULATOR_DEFINES_SVH
`define PHASE_AVERAGE_PI_REGULATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PAPR_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PAPR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hdl/papr_pkg.sv =====
// ----------------------------------------------------------------------------
// papr_pkg
// widths, constants, codes and the sequencer program of the phase regulator
// ----------------------------------------------------------------------------
package papr_pkg;

    // default geometry of the sample ring
    localparam int RING_DEPTH_DEF = 20;
    localparam int AVG_COUNT_DEF  = 10;

    // port widths
    localparam int SAMPLE_W   = 12;
    localparam int PIN_W      = 17;
    localparam int DRIVE_W    = 33;
    localparam int MODE_W     = 2;
    localparam int GAIN_W     = 24;
    localparam int TARGET_W   = 25;
    localparam int LIMIT_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // internal arithmetic widths (Q16.16 values)
    localparam int FRAC_W      = 16;
    localparam int MEAS_W      = 27;
    localparam int MUL_A_W     = 27;
    localparam int MUL_B_W     = 26;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int DRV_W       = 38;
    localparam int RECIP_SHIFT = 24;

    // conversion constants
    localparam int ANGLE_OFFSET = 100;
    localparam int DEG_SCALE    = 360 * (1 << FRAC_W) / 4096;
    localparam int DIR_BONUS    = 10000;

    // controller modes
    localparam logic [MODE_W-1:0] CM_P    = 2'd0;
    localparam logic [MODE_W-1:0] CM_PI   = 2'd1;
    localparam logic [MODE_W-1:0] CM_PASS = 2'd2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CTRL_MODE    = 3'd0,
        CFG_PROP_GAIN    = 3'd1,
        CFG_INT_GAIN     = 3'd2,
        CFG_PHASE_TARGET = 3'd3,
        CFG_OUTPUT_LIMIT = 3'd4
    } t_cfg_reg;

    // datapath operations
    typedef enum logic [4:0] {
        U_IDLE, U_SUM, U_DRAIN, U_MUL_RECIP, U_TAKE_Q, U_MUL_N, U_FIX_Q,
        U_MUL_DEG, U_MEAS, U_GAIN_SUM, U_MUL_MG, U_MUL_PK, U_SUB, U_PI_SUM,
        U_MUL_MK, U_P_DRV, U_LIMIT, U_EMIT, U_PASS
    } t_uop;

    // sequencer jump conditions
    typedef enum logic [2:0] {
        J_NEXT, J_GOTO, J_START, J_LOOP, J_PASS, J_PROP, J_OUT
    } t_jump;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        t_uop  uop;
        t_jump jump;
        t_step target;
    } t_uword;

    // named program steps
    localparam t_step ST_IDLE  = 5'd0;
    localparam t_step ST_PROP  = 5'd14;
    localparam t_step ST_LIMIT = 5'd16;
    localparam t_step ST_PASS  = 5'd18;

    // control store
    function automatic t_uword ucode(input t_step step);
        unique case (step)
            5'd0:    ucode = '{U_IDLE,      J_START, ST_IDLE};
            5'd1:    ucode = '{U_SUM,       J_LOOP,  ST_IDLE};
            5'd2:    ucode = '{U_DRAIN,     J_NEXT,  ST_IDLE};
            5'd3:    ucode = '{U_MUL_RECIP, J_NEXT,  ST_IDLE};
            5'd4:    ucode = '{U_TAKE_Q,    J_NEXT,  ST_IDLE};
            5'd5:    ucode = '{U_MUL_N,     J_NEXT,  ST_IDLE};
            5'd6:    ucode = '{U_FIX_Q,     J_NEXT,  ST_IDLE};
            5'd7:    ucode = '{U_MUL_DEG,   J_NEXT,  ST_IDLE};
            5'd8:    ucode = '{U_MEAS,      J_PASS,  ST_PASS};
            5'd9:    ucode = '{U_GAIN_SUM,  J_PROP,  ST_PROP};
            5'd10:   ucode = '{U_MUL_MG,    J_NEXT,  ST_IDLE};
            5'd11:   ucode = '{U_MUL_PK,    J_NEXT,  ST_IDLE};
            5'd12:   ucode = '{U_SUB,       J_NEXT,  ST_IDLE};
            5'd13:   ucode = '{U_PI_SUM,    J_GOTO,  ST_LIMIT};
            5'd14:   ucode = '{U_MUL_MK,    J_NEXT,  ST_IDLE};
            5'd15:   ucode = '{U_P_DRV,     J_NEXT,  ST_IDLE};
            5'd16:   ucode = '{U_LIMIT,     J_NEXT,  ST_IDLE};
            5'd17:   ucode = '{U_EMIT,      J_OUT,   ST_IDLE};
            5'd18:   ucode = '{U_PASS,      J_OUT,   ST_IDLE};
            default: ucode = '{U_IDLE,      J_GOTO,  ST_IDLE};
        endcase
    endfunction

endpackage

// ===== hdl/phase_average_pi_regulator.sv =====
// ----------------------------------------------------------------------------
// phase_average_pi_regulator
// phase sample averaging with P / incremental PI regulation or passthrough, microcoded
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries i_mode, i_phase_sample and
// i_direction. A sample transfer (mode 0) writes the sample into the ring in
// the cycle it is taken and gives no result; a new item is taken the cycle
// after. A tick transfer (mode 1) starts the control program, which averages
// ring entries 0..AVG_COUNT-1 and runs the selected control law.
// Output channel (o_out_valid / i_out_ready) carries o_pin_word and
// o_drive_value, one result per tick, from an output register.
// The tick program runs the ring read loop (one entry a cycle) and then its
// products on the single shared 27x26 multiplier; the next item can be taken
// in the cycle after the result is written.
// While a result waits in the output register the block is back at idle and
// takes further items; a second result waits in the emit step until the
// receiver takes the first. Configuration writes via i_cfg_we are to be made
// only while the block is idle; the block itself does not enforce this.
// Reset clears the ring (per-entry valid bits), the history and the
// configuration registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module phase_average_pi_regulator #(
    parameter int RING_DEPTH = papr_pkg::RING_DEPTH_DEF,
    parameter int AVG_COUNT  = papr_pkg::AVG_COUNT_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [papr_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [papr_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_mode,
    input  logic [papr_pkg::SAMPLE_W-1:0]          i_phase_sample,
    input  logic                                   i_direction,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [papr_pkg::PIN_W-1:0]             o_pin_word,
    output logic signed [papr_pkg::DRIVE_W-1:0]    o_drive_value
);
    import papr_pkg::*;

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int SPAN   = (AVG_COUNT > RING_DEPTH) ? AVG_COUNT : RING_DEPTH;
    localparam int IDX_W  = $clog2(SPAN + 1);
    localparam int SUM_W  = $clog2(AVG_COUNT * ((1 << SAMPLE_W) - 1) + 1);
    localparam int RECIP  = (1 << RECIP_SHIFT) / AVG_COUNT;

    // configuration registers
    logic [MODE_W-1:0]          r_ctrl_mode;
    logic signed [GAIN_W-1:0]   r_prop_gain;
    logic signed [GAIN_W-1:0]   r_int_gain;
    logic signed [TARGET_W-1:0] r_phase_target;
    logic [LIMIT_W-1:0]         r_output_limit;

    // sample ring and its bookkeeping
    logic [SAMPLE_W-1:0]   r_ring [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_ring_vld;
    logic [ADDR_W-1:0]     r_wr_slot;
    logic [SAMPLE_W-1:0]   r_rd_data;
    logic                  r_rd_ok;

    // sequencer
    t_step  r_step, n_step, step_inc;
    t_uword uword;

    // datapath registers
    logic [IDX_W-1:0]           r_idx;
    logic [SUM_W-1:0]           r_sum;
    logic [SAMPLE_W-1:0]        r_avg;
    logic                       r_dir;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PROD_W-1:0]   r_acc;
    logic signed [MEAS_W-1:0]   r_meas;
    logic signed [MEAS_W-1:0]   r_prev_meas;
    logic signed [DRV_W-1:0]    r_drive;
    logic signed [DRIVE_W-1:0]  r_prev_drive;

    // output register
    logic                       r_out_valid;
    logic [PIN_W-1:0]           r_pin_word;
    logic signed [DRIVE_W-1:0]  r_drive_value;

    // combinational helpers
    logic                       in_xfer, tick_xfer, sample_xfer, out_free, emit_fire;
    logic                       rd_in_range;
    logic [ADDR_W-1:0]          rd_addr;
    logic [SUM_W-1:0]           sum_add, rem;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [MEAS_W-1:0]   angle, meas_n;
    logic signed [DRV_W-1:0]    lim_q, lim_sum;
    logic [PIN_W-1:0]           pass_pin;

    // handshakes
    assign o_in_ready  = (uword.uop == U_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign tick_xfer   = in_xfer && i_mode;
    assign sample_xfer = in_xfer && !i_mode;
    assign out_free    = !r_out_valid || i_out_ready;
    assign emit_fire   = ((uword.uop == U_EMIT) || (uword.uop == U_PASS)) && out_free;

    // control word fetch
    always_comb begin
        uword    = ucode(r_step);
        step_inc = r_step + STEP_W'(1);
    end

    // next step
    always_comb begin
        unique case (uword.jump)
            J_NEXT:  n_step = step_inc;
            J_GOTO:  n_step = uword.target;
            J_START: n_step = tick_xfer ? step_inc : r_step;
            J_LOOP:  n_step = (r_idx != IDX_W'(AVG_COUNT - 1)) ? r_step : step_inc;
            J_PASS:  n_step = (r_ctrl_mode >= CM_PASS) ? uword.target : step_inc;
            J_PROP:  n_step = (r_ctrl_mode == CM_P) ? uword.target : step_inc;
            J_OUT:   n_step = out_free ? uword.target : r_step;
            default: n_step = ST_IDLE;
        endcase
    end

    // ring read address, entries past the ring count as zero
    assign rd_in_range = (r_idx < IDX_W'(RING_DEPTH));
    assign rd_addr     = rd_in_range ? r_idx[ADDR_W-1:0] : '0;

    // accumulate, remainder and conversion terms
    assign sum_add  = r_sum + (r_rd_ok ? SUM_W'(r_rd_data) : '0);
    assign rem      = r_sum - r_prod[SUM_W-1:0];
    assign angle    = r_prod[MEAS_W-1:0];
    assign meas_n   = MEAS_W'(r_phase_target) + (r_dir ? -angle : angle);
    assign lim_q    = $signed({{(DRV_W - LIMIT_W - FRAC_W){1'b0}}, r_output_limit,
                               {FRAC_W{1'b0}}});
    assign lim_sum  = r_drive + lim_q;
    assign pass_pin = PIN_W'(r_avg) + PIN_W'(r_output_limit)
                    + (r_dir ? PIN_W'(DIR_BONUS) : '0);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (uword.uop)
            U_MUL_RECIP: begin
                mul_a = $signed({{(MUL_A_W - SUM_W){1'b0}}, r_sum});
                mul_b = MUL_B_W'(RECIP);
            end
            U_MUL_N: begin
                mul_a = $signed({{(MUL_A_W - SAMPLE_W){1'b0}}, r_avg});
                mul_b = MUL_B_W'(AVG_COUNT);
            end
            U_MUL_DEG: begin
                mul_a = $signed({{(MUL_A_W - SAMPLE_W){1'b0}}, r_avg})
                      - MUL_A_W'(ANGLE_OFFSET);
                mul_b = MUL_B_W'(DEG_SCALE);
            end
            U_MUL_MG: begin
                mul_a = r_meas;
                mul_b = r_acc[MUL_B_W-1:0];
            end
            U_MUL_PK: begin
                mul_a = r_prev_meas;
                mul_b = MUL_B_W'(r_prop_gain);
            end
            U_MUL_MK: begin
                mul_a = r_meas;
                mul_b = MUL_B_W'(r_prop_gain);
            end
            default: begin
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ring memory
    always_ff @(posedge i_clk) begin
        if (sample_xfer) begin
            r_ring[r_wr_slot] <= i_phase_sample;
        end
        r_rd_data <= r_ring[rd_addr];
    end

    // datapath driven by the control word
    always_ff @(posedge i_clk) begin
        unique case (uword.uop)
            U_IDLE: begin
                if (tick_xfer) begin
                    r_sum <= '0;
                    r_idx <= '0;
                    r_dir <= i_direction;
                end
            end
            U_SUM: begin
                r_sum <= sum_add;
                r_idx <= r_idx + IDX_W'(1);
            end
            U_DRAIN:     r_sum <= sum_add;
            U_MUL_RECIP: r_prod <= mul_p;
            U_TAKE_Q:    r_avg <= r_prod[RECIP_SHIFT +: SAMPLE_W];
            U_MUL_N:     r_prod <= mul_p;
            U_FIX_Q: begin
                if (rem >= SUM_W'(AVG_COUNT)) begin
                    r_avg <= r_avg + SAMPLE_W'(1);
                end
            end
            U_MUL_DEG:   r_prod <= mul_p;
            U_MEAS:      r_meas <= meas_n;
            U_GAIN_SUM:  r_acc <= PROD_W'(r_prop_gain) + PROD_W'(r_int_gain);
            U_MUL_MG:    r_prod <= mul_p;
            U_MUL_PK: begin
                r_acc  <= r_prod;
                r_prod <= mul_p;
            end
            U_SUB:       r_acc <= r_acc - r_prod;
            U_PI_SUM:    r_drive <= DRV_W'(r_prev_drive) + DRV_W'(r_acc >>> FRAC_W);
            U_MUL_MK:    r_prod <= mul_p;
            U_P_DRV:     r_drive <= DRV_W'((-r_prod) >>> FRAC_W);
            U_LIMIT: begin
                if ((r_drive < -lim_q) || (r_drive > lim_q)) begin
                    r_drive <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            if (uword.uop == U_EMIT) begin
                r_pin_word    <= lim_sum[FRAC_W +: PIN_W];
                r_drive_value <= r_drive[DRIVE_W-1:0];
            end else begin
                r_pin_word    <= pass_pin;
                r_drive_value <= r_prev_drive;
            end
        end
    end

    // control state, configuration and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step         <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_ring_vld     <= '0;
            r_wr_slot      <= '0;
            r_rd_ok        <= 1'b0;
            r_ctrl_mode    <= CM_PI;
            r_prop_gain    <= -24'sd6554;
            r_int_gain     <= -24'sd983;
            r_phase_target <= '0;
            r_output_limit <= 16'd2000;
            r_prev_drive   <= '0;
            r_prev_meas    <= '0;
        end else begin
            r_step  <= n_step;
            r_rd_ok <= (uword.uop == U_SUM) && rd_in_range && r_ring_vld[rd_addr];

            // sample store and slot wrap
            if (sample_xfer) begin
                r_ring_vld[r_wr_slot] <= 1'b1;
                r_wr_slot <= (r_wr_slot == ADDR_W'(RING_DEPTH - 1)) ? '0
                           : r_wr_slot + ADDR_W'(1);
            end

            // register writes, unknown indexes ignored
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_CTRL_MODE:    r_ctrl_mode    <= i_cfg_data[MODE_W-1:0];
                    CFG_PROP_GAIN:    r_prop_gain    <= i_cfg_data[GAIN_W-1:0];
                    CFG_INT_GAIN:     r_int_gain     <= i_cfg_data[GAIN_W-1:0];
                    CFG_PHASE_TARGET: r_phase_target <= i_cfg_data[TARGET_W-1:0];
                    CFG_OUTPUT_LIMIT: r_output_limit <= i_cfg_data[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end

            // output register handshake
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (emit_fire) begin
                r_out_valid <= 1'b1;
                r_prev_meas <= r_meas;
                if (uword.uop == U_EMIT) begin
                    r_prev_drive <= r_drive[DRIVE_W-1:0];
                end
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pin_word    = r_pin_word;
    assign o_drive_value = r_drive_value;

endmodule

// ===== hdl/papr_checker.sv =====
// ----------------------------------------------------------------------------
// papr_checker
// port-level checks on the phase regulator, bound to the top level
// ----------------------------------------------------------------------------
`include "phase_average_pi_regulator_defines.svh"

module papr_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_ready,
    input logic                                   i_mode,
    input logic                                   o_out_valid,
    input logic                                   i_out_ready,
    input logic [papr_pkg::PIN_W-1:0]             o_pin_word,
    input logic signed [papr_pkg::DRIVE_W-1:0]    o_drive_value
);
    import papr_pkg::*;

    // a stalled result holds
    `PAPR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_pin_word) && $stable(o_drive_value), "stalled result changed")

    // idle with an empty output register never produces a result next cycle
    `PAPR_ASSERT_NEXT(a_idle_no_result, i_clk, i_rst_n, !o_out_valid && o_in_ready, !o_out_valid, "result appeared without a tick program")

    // a tick transfer starts the program and blocks the input
    `PAPR_ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_mode, !o_in_ready, "input still ready after tick transfer")

    // a result drained while idle leaves the output register empty
    `PAPR_ASSERT_NEXT(a_drain_idle, i_clk, i_rst_n, o_out_valid && i_out_ready && o_in_ready, !o_out_valid, "result repeated after transfer")

endmodule

bind phase_average_pi_regulator papr_checker u_papr_checker (.*);
